@@ rtl/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder package
// Frame positions, CRC-8 constants, scaling constants and the byte-wide CRC.
// ----------------------------------------------------------------------------
package htfd_pkg;

	typedef logic [2:0] htfd_pos_t;

	localparam htfd_pos_t PosTempMsb = 3'd0;
	localparam htfd_pos_t PosTempLsb = 3'd1;
	localparam htfd_pos_t PosTempCrc = 3'd2;
	localparam htfd_pos_t PosHumMsb  = 3'd3;
	localparam htfd_pos_t PosHumLsb  = 3'd4;
	localparam htfd_pos_t PosHumCrc  = 3'd5;

	localparam logic [7:0] CrcPoly = 8'h31;
	localparam logic [7:0] CrcInit = 8'hFF;

	localparam int TempWidth = 15;
	localparam int HumWidth  = 14;

	localparam logic [14:0] TempSpan   = 15'd17500;
	localparam logic [14:0] HumSpan    = 15'd10000;
	localparam logic [14:0] TempOffset = 15'd4500;
	localparam logic [13:0] HumMax     = 14'd9999;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder
// Checks the two CRC-protected words of a six-byte sensor frame, scales them
// to hundredths and presents the held values after the sixth byte.
// ----------------------------------------------------------------------------
// A result is registered on the master side once the sixth byte of a frame
// has passed the input register; other bytes produce no result.
// One byte is accepted every cycle unless a held result stalls the sixth byte; the
// CRC update and one constant multiplication lie between input and result registers.
// An asynchronous low reset clears position, CRC, held values and valid flags.
module humidity_temp_frame_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
	output logic [1:0]  m_axis_tuser   // [0] temperature_ok, [1] humidity_ok
);
	import htfd_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;

	htfd_pos_t            pos_q;
	logic [7:0]           crc_q;
	logic [7:0]           high_q;
	logic [14:0]          scaled_q;
	logic                 temp_pass_q;
	logic [TempWidth-1:0] temp_q;
	logic [HumWidth-1:0]  hum_q;

	logic                 out_valid_q;
	logic [TempWidth-1:0] out_temp_q;
	logic [HumWidth-1:0]  out_hum_q;
	logic                 out_temp_ok_q;
	logic                 out_hum_ok_q;

	htfd_pos_t            pos;
	logic [7:0]           crc_in;
	logic [7:0]           crc_next;
	logic                 crc_match;
	logic [15:0]          raw;
	logic [14:0]          span;
	logic [30:0]          prod;
	logic [31:0]          recip_sum;
	logic [14:0]          quot;
	logic                 produces;
	logic                 go;
	logic                 fire;

	assign pos = (start_s1 || pos_q > PosHumCrc) ? PosTempMsb : pos_q;

	assign crc_in    = (pos == PosTempMsb || pos == PosHumMsb) ? CrcInit : crc_q;
	assign crc_next  = crc8_byte(crc_in, byte_s1);
	assign crc_match = (crc_q == byte_s1);

	// Division by 65535 is exact here as a reciprocal add and shift.
	assign raw       = {high_q, byte_s1[7:2], 2'b00};
	assign span      = (pos == PosTempLsb) ? TempSpan : HumSpan;
	assign prod      = 31'(raw) * 31'(span);
	assign recip_sum = 32'(prod) + 32'(prod[30:16]) + 32'd1;
	assign quot      = recip_sum[30:16];

	assign produces      = valid_s1 && (pos == PosHumCrc);
	assign go            = !produces || !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && go;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= PosTempMsb;
			crc_q         <= CrcInit;
			high_q        <= '0;
			scaled_q      <= '0;
			temp_pass_q   <= 1'b0;
			temp_q        <= '0;
			hum_q         <= '0;
			out_valid_q   <= 1'b0;
			out_temp_q    <= '0;
			out_hum_q     <= '0;
			out_temp_ok_q <= 1'b0;
			out_hum_ok_q  <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				case (pos)
					PosTempMsb, PosHumMsb: begin
						if (pos == PosTempMsb) begin
							temp_pass_q <= 1'b0;
						end
						crc_q  <= crc_next;
						high_q <= byte_s1;
						pos_q  <= pos + 3'd1;
					end
					PosTempLsb, PosHumLsb: begin
						crc_q    <= crc_next;
						scaled_q <= quot;
						pos_q    <= pos + 3'd1;
					end
					PosTempCrc: begin
						temp_pass_q <= crc_match;
						if (crc_match) begin
							temp_q <= scaled_q - TempOffset;
						end
						crc_q <= CrcInit;
						pos_q <= PosHumMsb;
					end
					PosHumCrc: begin
						if (crc_match) begin
							hum_q <= scaled_q[HumWidth-1:0];
						end
						crc_q         <= CrcInit;
						pos_q         <= PosTempMsb;
						out_valid_q   <= 1'b1;
						out_temp_q    <= temp_q;
						out_hum_q     <= crc_match ? scaled_q[HumWidth-1:0] : hum_q;
						out_temp_ok_q <= temp_pass_q;
						out_hum_ok_q  <= crc_match;
					end
					default: begin
						pos_q <= PosTempMsb;
					end
				endcase
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_hum_q, out_temp_q};
	assign m_axis_tuser  = {out_hum_ok_q, out_temp_ok_q};

	// The frame position never leaves the six valid positions.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosHumCrc)
		else $error("frame position out of range");

	// The held humidity stays within its scaled range.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		hum_q <= HumMax)
		else $error("held humidity out of range");

	// Completing a frame restarts the position and the CRC and raises result valid.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produces |=> pos_q == PosTempMsb && crc_q == CrcInit && out_valid_q)
		else $error("frame end did not restart decoder");

	// The temperature check byte reloads the CRC for the humidity word.
	a_temp_crc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pos == PosTempCrc |=> pos_q == PosHumMsb && crc_q == CrcInit)
		else $error("temperature check did not reload CRC");

	// A request is refused only while a result is held and not taken.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without an output stall");

endmodule
